### rtl/sis_pkg.sv
// ============================================================================
// sis_pkg
// Shared types, constants and the multiply-accumulate micro-program of the
// Sampson inlier scorer.
// ============================================================================
package sis_pkg;

    localparam int NUM_OPS   = 34;
    localparam int DIV_STEPS = 32;
    localparam int SRC_W     = 54;
    localparam int ACC_W     = 112;
    localparam int DEN_W     = 76;
    localparam int NUM_W     = 108;
    localparam int REM_W     = 116;

    localparam logic [41:0] SUM_MAX      = 42'h3FF_FFFF_FFFF;
    localparam logic [10:0] COUNT_MAX    = 11'd2047;
    localparam logic [31:0] DIST_MAX     = 32'hFFFF_FFFF;
    localparam logic [31:0] CORNER_RESET = 32'h4000_0000;
    localparam logic [31:0] LIMIT_RESET  = 32'd196608;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_MIXED  = 3'd1,
        REG_ROW1   = 3'd2,
        REG_ROW2   = 3'd3,
        REG_CORNER = 3'd4,
        REG_LIMIT  = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        A_F00    = 4'd0,
        A_F01    = 4'd1,
        A_F02    = 4'd2,
        A_F10    = 4'd3,
        A_F11    = 4'd4,
        A_F12    = 4'd5,
        A_F20    = 4'd6,
        A_F21    = 4'd7,
        A_F22    = 4'd8,
        A_SRC_HI = 4'd9,
        A_SRC_LO = 4'd10,
        A_MAG_HI = 4'd11,
        A_MAG_LO = 4'd12
    } a_sel_t;

    typedef enum logic [2:0] {
        B_X      = 3'd0,
        B_Y      = 3'd1,
        B_XP     = 3'd2,
        B_YP     = 3'd3,
        B_SIXTEEN = 3'd4,
        B_MAG_HI = 3'd5,
        B_MAG_LO = 3'd6
    } b_sel_t;

    typedef enum logic [2:0] {
        S_A1 = 3'd0,
        S_A2 = 3'd1,
        S_B1 = 3'd2,
        S_B2 = 3'd3,
        S_E  = 3'd4
    } src_sel_t;

    typedef enum logic [2:0] {
        SH_0  = 3'd0,
        SH_17 = 3'd1,
        SH_28 = 3'd2,
        SH_54 = 3'd3
    } shift_t;

    typedef enum logic [1:0] {
        INIT_ZERO = 2'd0,
        INIT_C    = 2'd1,
        INIT_KEEP = 2'd2
    } init_t;

    typedef enum logic [3:0] {
        D_NONE = 4'd0,
        D_A1   = 4'd1,
        D_A2   = 4'd2,
        D_B1   = 4'd3,
        D_B2   = 4'd4,
        D_C    = 4'd5,
        D_E    = 4'd6,
        D_DEN  = 4'd7,
        D_NUM  = 4'd8
    } dest_t;

    typedef struct packed {
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        src_sel_t src;
        shift_t   sh;
        init_t    init;
        dest_t    dest;
    } mac_op_t;

    typedef struct packed {
        logic [8:0][31:0] f;
        logic [31:0]      limit;
    } coef_t;

    typedef struct packed {
        logic    capture;
        logic    op_valid;
        mac_op_t op;
        logic    div_init;
        logic    div_step;
        logic    finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic mac_op_t make_op(a_sel_t a, b_sel_t b, src_sel_t s, shift_t sh,
                                        init_t init, dest_t dest);
        mac_op_t r;
        r.a_sel = a;
        r.b_sel = b;
        r.src   = s;
        r.sh    = sh;
        r.init  = init;
        r.dest  = dest;
        return r;
    endfunction

    // Linear terms first, then the epipolar error, the denominator squares
    // and finally the square of the error. Each square is split into halves.
    function automatic mac_op_t get_op(logic [5:0] step);
        mac_op_t r;
        case (step)
            6'd0:  r = make_op(A_F00, B_X, S_A1, SH_0, INIT_ZERO, D_NONE);
            6'd1:  r = make_op(A_F01, B_Y, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd2:  r = make_op(A_F02, B_SIXTEEN, S_A1, SH_0, INIT_KEEP, D_A1);
            6'd3:  r = make_op(A_F10, B_X, S_A1, SH_0, INIT_ZERO, D_NONE);
            6'd4:  r = make_op(A_F11, B_Y, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd5:  r = make_op(A_F12, B_SIXTEEN, S_A1, SH_0, INIT_KEEP, D_A2);
            6'd6:  r = make_op(A_F00, B_XP, S_A1, SH_0, INIT_ZERO, D_NONE);
            6'd7:  r = make_op(A_F10, B_YP, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd8:  r = make_op(A_F20, B_SIXTEEN, S_A1, SH_0, INIT_KEEP, D_B1);
            6'd9:  r = make_op(A_F01, B_XP, S_A1, SH_0, INIT_ZERO, D_NONE);
            6'd10: r = make_op(A_F11, B_YP, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd11: r = make_op(A_F21, B_SIXTEEN, S_A1, SH_0, INIT_KEEP, D_B2);
            6'd12: r = make_op(A_F20, B_X, S_A1, SH_0, INIT_ZERO, D_NONE);
            6'd13: r = make_op(A_F21, B_Y, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd14: r = make_op(A_F22, B_SIXTEEN, S_A1, SH_0, INIT_KEEP, D_C);
            6'd15: r = make_op(A_SRC_HI, B_XP, S_A1, SH_17, INIT_C, D_NONE);
            6'd16: r = make_op(A_SRC_LO, B_XP, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd17: r = make_op(A_SRC_HI, B_YP, S_A2, SH_17, INIT_KEEP, D_NONE);
            6'd18: r = make_op(A_SRC_LO, B_YP, S_A2, SH_0, INIT_KEEP, D_E);
            6'd19: r = make_op(A_MAG_HI, B_MAG_HI, S_A1, SH_54, INIT_ZERO, D_NONE);
            6'd20: r = make_op(A_MAG_HI, B_MAG_LO, S_A1, SH_28, INIT_KEEP, D_NONE);
            6'd21: r = make_op(A_MAG_LO, B_MAG_LO, S_A1, SH_0, INIT_KEEP, D_NONE);
            6'd22: r = make_op(A_MAG_HI, B_MAG_HI, S_A2, SH_54, INIT_KEEP, D_NONE);
            6'd23: r = make_op(A_MAG_HI, B_MAG_LO, S_A2, SH_28, INIT_KEEP, D_NONE);
            6'd24: r = make_op(A_MAG_LO, B_MAG_LO, S_A2, SH_0, INIT_KEEP, D_NONE);
            6'd25: r = make_op(A_MAG_HI, B_MAG_HI, S_B1, SH_54, INIT_KEEP, D_NONE);
            6'd26: r = make_op(A_MAG_HI, B_MAG_LO, S_B1, SH_28, INIT_KEEP, D_NONE);
            6'd27: r = make_op(A_MAG_LO, B_MAG_LO, S_B1, SH_0, INIT_KEEP, D_NONE);
            6'd28: r = make_op(A_MAG_HI, B_MAG_HI, S_B2, SH_54, INIT_KEEP, D_NONE);
            6'd29: r = make_op(A_MAG_HI, B_MAG_LO, S_B2, SH_28, INIT_KEEP, D_NONE);
            6'd30: r = make_op(A_MAG_LO, B_MAG_LO, S_B2, SH_0, INIT_KEEP, D_DEN);
            6'd31: r = make_op(A_MAG_HI, B_MAG_HI, S_E, SH_54, INIT_ZERO, D_NONE);
            6'd32: r = make_op(A_MAG_HI, B_MAG_LO, S_E, SH_28, INIT_KEEP, D_NONE);
            6'd33: r = make_op(A_MAG_LO, B_MAG_LO, S_E, SH_0, INIT_KEEP, D_NUM);
            default: r = make_op(A_F00, B_X, S_A1, SH_0, INIT_KEEP, D_NONE);
        endcase
        return r;
    endfunction

endpackage

### rtl/sampson_inlier_scorer_top.sv
// ============================================================================
// sampson_inlier_scorer_top
// Sampson-distance epipolar inlier test with per-set running totals.
// ============================================================================
// One correspondence enters per transaction on the s_ channel; one result
// leaves per transaction on the m_ channel, in order. s_tlast marks the last
// correspondence of a set; m_tlast repeats it, and the totals in that result
// are final for the set, after which index, sum and count restart at zero.
// The user must write the matrix and threshold over the APB port only while
// idle; the block itself does not enforce it. An accepted input passes
// through the shared multiply-accumulate program (34 products through one
// 34x34 multiplier, then the accumulation of the last), one setup step and
// the one-bit-per-cycle divider for the 32-bit quotient, and finally the load
// of the output register. One item is worked on at a time, and the next
// input is accepted in the cycle after that result is loaded.
// The output register holds a finished result while the receiver stalls;
// the next input is accepted and computed meanwhile, and its result waits
// until the register is free. Reset clears the totals, empties the output
// and restores the default matrix corner and threshold.
// ============================================================================
module sampson_inlier_scorer_top
    import sis_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // ref_x, ref_y, cur_x, cur_y
    input  logic         s_tlast,   // final_point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // point_index, distance, is_inlier, degenerate,
                                    // error_sum, inlier_total, zero padding
    output logic         m_tlast,   // set_done
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    coef_t      coef;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    sis_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    sis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sis_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .coef      (coef),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/sis_regs.sv
// ============================================================================
// sis_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module sis_regs
    import sis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output coef_t       coef
);

    logic [63:0] row0_reg;
    logic [63:0] mixed_reg;
    logic [63:0] row1_reg;
    logic [63:0] row2_reg;
    logic [31:0] corner_reg;
    logic [31:0] limit_reg;
    logic        wr_en;
    reg_index_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_index_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg   <= '0;
            mixed_reg  <= '0;
            row1_reg   <= '0;
            row2_reg   <= '0;
            corner_reg <= CORNER_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ROW0:   row0_reg   <= pwdata;
                REG_MIXED:  mixed_reg  <= pwdata;
                REG_ROW1:   row1_reg   <= pwdata;
                REG_ROW2:   row2_reg   <= pwdata;
                REG_CORNER: corner_reg <= pwdata[31:0];
                REG_LIMIT:  limit_reg  <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW0:   prdata = row0_reg;
            REG_MIXED:  prdata = mixed_reg;
            REG_ROW1:   prdata = row1_reg;
            REG_ROW2:   prdata = row2_reg;
            REG_CORNER: prdata = {32'd0, corner_reg};
            REG_LIMIT:  prdata = {32'd0, limit_reg};
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        coef.f[0] = row0_reg[63:32];
        coef.f[1] = row0_reg[31:0];
        coef.f[2] = mixed_reg[63:32];
        coef.f[3] = mixed_reg[31:0];
        coef.f[4] = row1_reg[63:32];
        coef.f[5] = row1_reg[31:0];
        coef.f[6] = row2_reg[63:32];
        coef.f[7] = row2_reg[31:0];
        coef.f[8] = corner_reg;
        coef.limit = limit_reg;
    end

endmodule

### rtl/sis_ctrl.sv
// ============================================================================
// sis_ctrl
// Sequencer: walks the multiply-accumulate program, then the divider steps,
// then hands the result to the output register.
// ============================================================================
module sis_ctrl
    import sis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.op       = get_op(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                step_next   = '0;
                if (in_valid)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.op_valid = (step_reg < 6'(NUM_OPS));
                step_next    = step_reg + 6'd1;
                if (step_reg == 6'(NUM_OPS))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

### rtl/sis_datapath.sv
// ============================================================================
// sis_datapath
// Shared 34x34 multiplier with a wide accumulator, restoring divider,
// running totals and the output register.
// ============================================================================
module sis_datapath
    import sis_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    output dp_status_t   status,
    input  coef_t        coef,
    input  logic [63:0]  in_data,
    input  logic         in_last,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [103:0] out_data,
    output logic         out_last
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [15:0] x_reg, y_reg, xp_reg, yp_reg;
    logic        last_reg;

    logic signed [SRC_W-1:0] a1_reg, a2_reg, b1_reg, b2_reg, c_reg, e_reg;
    logic signed [SRC_W-1:0] src_val;
    logic [SRC_W-1:0]        mag;
    logic signed [33:0]      a_opnd, b_opnd;
    logic signed [67:0]      prod_reg;
    logic                    p_valid_reg;
    shift_t                  p_sh_reg;
    init_t                   p_init_reg;
    dest_t                   p_dest_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next, ext, shifted, base;
    logic signed [ACC_W-1:0] acc_sh14, acc_sh10;
    logic [DEN_W-1:0]        den_reg;
    logic [NUM_W-1:0]        num_reg;

    logic [REM_W-1:0] rem_reg, dsh_reg;
    logic [31:0]      q_reg;
    logic             sat_reg, degen_reg, ge;

    logic [IDX_W-1:0] idx_reg;
    logic [41:0]      sum_reg;
    logic [10:0]      cnt_reg;
    logic [31:0]      dist_val;
    logic             inl;
    logic [42:0]      sum_wide;
    logic [41:0]      sum_new;
    logic [10:0]      cnt_new;

    logic        out_valid_reg;
    logic [9:0]  idx_out_reg;
    logic [31:0] dist_out_reg;
    logic        inl_out_reg, degen_out_reg, last_out_reg;
    logic [41:0] sum_out_reg;
    logic [10:0] cnt_out_reg;

    // Operand selection.
    always_comb
    begin
        case (cmd.op.src)
            S_A1:    src_val = a1_reg;
            S_A2:    src_val = a2_reg;
            S_B1:    src_val = b1_reg;
            S_B2:    src_val = b2_reg;
            default: src_val = e_reg;
        endcase
        mag = src_val[SRC_W-1] ? (~src_val + 54'd1) : src_val;

        case (cmd.op.a_sel)
            A_SRC_HI: a_opnd = src_val[50:17];
            A_SRC_LO: a_opnd = {17'd0, src_val[16:0]};
            A_MAG_HI: a_opnd = {7'd0, mag[53:27]};
            A_MAG_LO: a_opnd = {7'd0, mag[26:0]};
            default:  a_opnd = {{2{coef.f[4'(cmd.op.a_sel)][31]}}, coef.f[4'(cmd.op.a_sel)]};
        endcase

        case (cmd.op.b_sel)
            B_X:       b_opnd = {18'd0, x_reg};
            B_Y:       b_opnd = {18'd0, y_reg};
            B_XP:      b_opnd = {18'd0, xp_reg};
            B_YP:      b_opnd = {18'd0, yp_reg};
            B_SIXTEEN: b_opnd = 34'sd16;
            B_MAG_HI:  b_opnd = {7'd0, mag[53:27]};
            default:   b_opnd = {7'd0, mag[26:0]};
        endcase
    end

    // Accumulate stage.
    always_comb
    begin
        ext = {{(ACC_W - 68){prod_reg[67]}}, prod_reg};
        case (p_sh_reg)
            SH_17:   shifted = ext <<< 17;
            SH_28:   shifted = ext <<< 28;
            SH_54:   shifted = ext <<< 54;
            default: shifted = ext;
        endcase
        case (p_init_reg)
            INIT_ZERO: base = '0;
            INIT_C:    base = {{(ACC_W - SRC_W){c_reg[SRC_W-1]}}, c_reg};
            default:   base = acc_reg;
        endcase
        acc_next = base + shifted;
        acc_sh14 = acc_next >>> 14;
        acc_sh10 = acc_next >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= in_data[15:0];
            y_reg    <= in_data[31:16];
            xp_reg   <= in_data[47:32];
            yp_reg   <= in_data[63:48];
            last_reg <= in_last;
        end
        prod_reg   <= a_opnd * b_opnd;
        p_sh_reg   <= cmd.op.sh;
        p_init_reg <= cmd.op.init;
        p_dest_reg <= cmd.op.dest;
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
            case (p_dest_reg)
                D_A1:    a1_reg  <= acc_sh14[SRC_W-1:0];
                D_A2:    a2_reg  <= acc_sh14[SRC_W-1:0];
                D_B1:    b1_reg  <= acc_sh14[SRC_W-1:0];
                D_B2:    b2_reg  <= acc_sh14[SRC_W-1:0];
                D_C:     c_reg   <= acc_sh10[SRC_W-1:0];
                D_E:     e_reg   <= acc_next[SRC_W-1:0];
                D_DEN:   den_reg <= acc_next[DEN_W-1:0];
                D_NUM:   num_reg <= acc_next[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.op_valid;
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg   <= {num_reg, 8'd0};
            dsh_reg   <= {9'd0, den_reg, 31'd0};
            q_reg     <= '0;
            sat_reg   <= ({num_reg, 8'd0} >= {8'd0, den_reg, 32'd0});
            degen_reg <= (den_reg == '0);
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[30:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Result and running totals.
    always_comb
    begin
        dist_val = (sat_reg || degen_reg) ? DIST_MAX : q_reg;
        inl      = !degen_reg && (dist_val < coef.limit);
        sum_wide = {1'b0, sum_reg} + {11'd0, dist_val};
        sum_new  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[41:0];
        cnt_new  = (inl && (cnt_reg != COUNT_MAX)) ? cnt_reg + 11'd1 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_new;
                    if (idx_reg == IDX_W'(MAX_POINTS - 1))
                    begin
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            idx_out_reg   <= 10'(idx_reg);
            dist_out_reg  <= dist_val;
            inl_out_reg   <= inl;
            degen_out_reg <= degen_reg;
            sum_out_reg   <= sum_new;
            cnt_out_reg   <= cnt_new;
            last_out_reg  <= last_reg;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_last  = last_out_reg;
    assign out_data  = {7'd0, cnt_out_reg, sum_out_reg, degen_out_reg, inl_out_reg,
                        dist_out_reg, idx_out_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("Result loaded over one that was not taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && degen_out_reg) |-> (dist_out_reg == DIST_MAX && !inl_out_reg))
        else $error("Degenerate point without saturated distance.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sum_out_reg >= {10'd0, dist_out_reg}))
        else $error("Running sum below the distance it includes.");

endmodule
